// ----- design/epc_pkg.sv -----
// shared types, codes and helper functions for the encoder position controller
package epc_pkg;

    localparam int COUNT_W = 32;
    localparam int TARGET_W = 31;
    localparam int MS_W = 17;
    localparam int TOL_W = 16;
    localparam int DUTY_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;

    localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};
    localparam logic DIR_INVERT = 1'b0;

    // operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_ZERO = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    // bridge drive codes
    localparam logic [1:0] DRV_COAST = 2'd0;
    localparam logic [1:0] DRV_FWD = 2'd1;
    localparam logic [1:0] DRV_REV = 2'd2;
    localparam logic [1:0] DRV_BRAKE = 2'd3;

    // event codes
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_REACHED = 2'd1;
    localparam logic [1:0] EV_TIMEOUT = 2'd2;
    localparam logic [1:0] EV_STUCK = 2'd3;

    // controller modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_MOVING = 2'd1;
    localparam logic [1:0] MODE_HOLDING = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_TOL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_ZONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DUTY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DUTY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TOL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DUTY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TMO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_TMO = 3'd7;

    // quadrature step codes
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_UP = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd2;

    typedef struct packed {
        logic [TOL_W-1:0]  position_tolerance;
        logic [TOL_W-1:0]  slow_zone;
        logic [DUTY_W-1:0] normal_duty;
        logic [DUTY_W-1:0] slow_duty;
        logic [TOL_W-1:0]  hold_tolerance;
        logic [DUTY_W-1:0] hold_duty;
        logic [TOL_W-1:0]  move_limit_ms;
        logic [TOL_W-1:0]  stuck_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic                holding;
        logic [COUNT_W-1:0]  count;
        logic [TARGET_W-1:0] target;
        logic                hold_pending;
        logic [MS_W-1:0]     elapsed;
        logic [MS_W-1:0]     unchanged;
        logic [COUNT_W-1:0]  last_abs;
    } ctrl_req_t;

    typedef struct packed {
        logic [1:0]         drive;
        logic [DUTY_W-1:0]  duty;
        logic [1:0]         event_res;
        logic [1:0]         mode;
        logic [MS_W-1:0]    unchanged;
        logic [COUNT_W-1:0] last_abs;
    } ctrl_resp_t;

    // previous phase in the upper two bits, new phase in the lower two
    function automatic logic [1:0] quad_step(input logic [3:0] sum);
        logic [1:0] step;
        if (sum inside {4'b1101, 4'b0100, 4'b0010, 4'b1011})
            step = STEP_UP;
        else if (sum inside {4'b1110, 4'b0111, 4'b0001, 4'b1000})
            step = STEP_DOWN;
        else
            step = STEP_NONE;
        return step;
    endfunction

    // magnitude of the count, most negative value maps to 2^31
    function automatic logic [COUNT_W-1:0] abs_count(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] mag;
        mag = cnt[COUNT_W-1] ? (~cnt + {{(COUNT_W-1){1'b0}}, 1'b1}) : cnt;
        return mag;
    endfunction

endpackage

// ----- design/epc_quad.sv -----
// quadrature phase decoder that steps the position count
module epc_quad
    import epc_pkg::*;
(
    input  logic [1:0]         phase_prev,
    input  logic               enc_a,
    input  logic               enc_b,
    input  logic [COUNT_W-1:0] count,
    output logic [COUNT_W-1:0] count_next
);

    logic [1:0] step;

    assign step = quad_step({phase_prev, enc_a, enc_b});

    always_comb
    begin
        case (step)
            STEP_UP:   count_next = count + {{(COUNT_W-1){1'b0}}, 1'b1};
            STEP_DOWN: count_next = count - {{(COUNT_W-1){1'b0}}, 1'b1};
            default:   count_next = count;
        endcase
    end

endmodule

// ----- design/epc_ctrl.sv -----
// bang-bang move and hold decision for one request
module epc_ctrl
    import epc_pkg::*;
(
    input  cfg_t       cfg,
    input  ctrl_req_t  req,
    output ctrl_resp_t resp
);

    logic [COUNT_W-1:0] cur;
    logic [COUNT_W:0]   err;
    logic [COUNT_W-1:0] aerr;
    logic               err_pos;
    logic [1:0]         push_drv;
    logic               changed;
    logic [MS_W-1:0]    unch_eff;
    logic               reached;
    logic               timed_out;
    logic               stuck;
    logic               in_slow;
    logic               in_hold_tol;

    assign cur = abs_count(req.count);
    // target is below 2^31 and cur at most 2^31, so 33 bits hold the difference
    assign err = {2'b00, req.target} - {1'b0, cur};
    assign aerr = err[COUNT_W] ? (~err[COUNT_W-1:0] + {{(COUNT_W-1){1'b0}}, 1'b1})
                               : err[COUNT_W-1:0];
    assign err_pos = !err[COUNT_W] && (err != '0);
    assign push_drv = (err_pos ^ DIR_INVERT) ? DRV_FWD : DRV_REV;

    assign changed = cur != req.last_abs;
    assign unch_eff = changed ? '0 : req.unchanged;

    assign reached = aerr <= {{(COUNT_W-TOL_W){1'b0}}, cfg.position_tolerance};
    assign timed_out = req.elapsed > {{(MS_W-TOL_W){1'b0}}, cfg.move_limit_ms};
    assign stuck = unch_eff > {{(MS_W-TOL_W){1'b0}}, cfg.stuck_timeout_ms};
    assign in_slow = aerr <= {{(COUNT_W-TOL_W){1'b0}}, cfg.slow_zone};
    assign in_hold_tol = aerr <= {{(COUNT_W-TOL_W){1'b0}}, cfg.hold_tolerance};

    always_comb
    begin
        resp.unchanged = req.unchanged;
        resp.last_abs = req.last_abs;
        resp.event_res = EV_NONE;
        if (req.holding)
        begin
            resp.mode = MODE_HOLDING;
            if (in_hold_tol)
            begin
                resp.drive = DRV_BRAKE;
                resp.duty = '0;
            end
            else
            begin
                resp.drive = push_drv;
                resp.duty = cfg.hold_duty;
            end
        end
        else
        begin
            // stuck tracking only advances when the move got past the first two checks
            if (!reached && !timed_out)
            begin
                resp.unchanged = unch_eff;
                resp.last_abs = cur;
            end
            if (reached)
                resp.event_res = EV_REACHED;
            else if (timed_out)
                resp.event_res = EV_TIMEOUT;
            else if (stuck)
                resp.event_res = EV_STUCK;

            if (resp.event_res != EV_NONE)
            begin
                resp.duty = '0;
                resp.drive = req.hold_pending ? DRV_BRAKE : DRV_COAST;
                resp.mode = req.hold_pending ? MODE_HOLDING : MODE_IDLE;
            end
            else
            begin
                resp.drive = push_drv;
                resp.duty = in_slow ? cfg.slow_duty : cfg.normal_duty;
                resp.mode = MODE_MOVING;
            end
        end
    end

endmodule

// ----- design/encoder_position_controller_unit.sv -----
// top level: encoder decoding, position controller state and stream stages
//
//  channel  | signals                         | contents
//  ---------+---------------------------------+----------------------------------------
//  s (in)   | s_tvalid s_tready s_tdata s_tuser | one sample, move, zero or release request
//  m (out)  | m_tvalid m_tready m_tdata       | drive, duty, event, mode, position
//  cfg      | cfg_we cfg_index cfg_data       | tuning register writes, no read-back
//
//  one request per cycle sustained while m_tready stays high; a request passes
//  through the input register and then the result register before its result
//  is valid on m.
//  the position and controller state update in the same cycle that moves a
//  request from the input register to the result register.
//  reset clears the controller state and valid flags and restores the register defaults; no sweep follows.
//  a stalled m side holds the result and both stages fill before s_tready drops.
module encoder_position_controller_unit
    import epc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // enc_a, enc_b, ms_strobe, target_ticks, hold_after
    input  logic [S_USER_W-1:0]   s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // drive, duty, event_res, mode, position
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;

    // input stage
    logic                in_valid_reg;
    logic [1:0]          op_reg;
    logic                enc_a_reg;
    logic                enc_b_reg;
    logic                strobe_reg;
    logic [TARGET_W-1:0] tgt_in_reg;
    logic                hold_in_reg;

    // controller state
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [1:0]          phase_reg, phase_next;
    logic [1:0]          mode_reg, mode_next;
    logic [TARGET_W-1:0] target_reg, target_next;
    logic                hold_reg, hold_next;
    logic [MS_W-1:0]     elapsed_reg, elapsed_next;
    logic [MS_W-1:0]     unch_reg, unch_next;
    logic [COUNT_W-1:0]  last_abs_reg, last_abs_next;

    // result stage
    logic                out_valid_reg;
    logic [1:0]          drive_reg, drive_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic [1:0]          event_reg, event_next;

    logic               advance;
    logic               fire;
    logic               is_move;
    logic [COUNT_W-1:0] count_dec;
    logic [MS_W-1:0]    elapsed_inc;
    logic [MS_W-1:0]    unch_inc;
    ctrl_req_t          req;
    ctrl_resp_t         resp;

    assign advance = !out_valid_reg || m_tready;
    assign fire = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(M_DATA_W-46){1'b0}}, count_reg, mode_reg, event_reg,
                      duty_reg, drive_reg};

    epc_quad u_quad (
        .phase_prev (phase_reg),
        .enc_a      (enc_a_reg),
        .enc_b      (enc_b_reg),
        .count      (count_reg),
        .count_next (count_dec)
    );

    assign is_move = op_reg == OP_MOVE;
    assign elapsed_inc = (strobe_reg && elapsed_reg != MS_MAX)
                       ? elapsed_reg + {{(MS_W-1){1'b0}}, 1'b1} : elapsed_reg;
    assign unch_inc = (strobe_reg && unch_reg != MS_MAX)
                    ? unch_reg + {{(MS_W-1){1'b0}}, 1'b1} : unch_reg;

    always_comb
    begin
        req.holding = (op_reg == OP_SAMPLE) && (mode_reg == MODE_HOLDING);
        req.count = is_move ? count_reg : count_dec;
        req.target = is_move ? tgt_in_reg : target_reg;
        req.hold_pending = is_move ? hold_in_reg : hold_reg;
        req.elapsed = is_move ? '0 : elapsed_inc;
        req.unchanged = is_move ? '0 : unch_inc;
        req.last_abs = is_move ? abs_count(count_reg) : last_abs_reg;
    end

    epc_ctrl u_ctrl (
        .cfg  (cfg_reg),
        .req  (req),
        .resp (resp)
    );

    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        mode_next = mode_reg;
        target_next = target_reg;
        hold_next = hold_reg;
        elapsed_next = elapsed_reg;
        unch_next = unch_reg;
        last_abs_next = last_abs_reg;
        drive_next = DRV_COAST;
        duty_next = '0;
        event_next = EV_NONE;
        case (op_reg)
            OP_SAMPLE:
            begin
                count_next = count_dec;
                phase_next = {enc_a_reg, enc_b_reg};
                if (mode_reg == MODE_MOVING)
                begin
                    elapsed_next = elapsed_inc;
                    unch_next = resp.unchanged;
                    last_abs_next = resp.last_abs;
                    mode_next = resp.mode;
                    drive_next = resp.drive;
                    duty_next = resp.duty;
                    event_next = resp.event_res;
                end
                else if (mode_reg == MODE_HOLDING)
                begin
                    drive_next = resp.drive;
                    duty_next = resp.duty;
                end
            end
            OP_MOVE:
            begin
                target_next = tgt_in_reg;
                hold_next = hold_in_reg;
                elapsed_next = '0;
                unch_next = resp.unchanged;
                last_abs_next = resp.last_abs;
                mode_next = resp.mode;
                drive_next = resp.drive;
                duty_next = resp.duty;
                event_next = resp.event_res;
            end
            OP_ZERO:
            begin
                mode_next = MODE_IDLE;
                count_next = '0;
                target_next = '0;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_tolerance <= 16'd5;
            cfg_reg.slow_zone <= 16'd50;
            cfg_reg.normal_duty <= 8'd200;
            cfg_reg.slow_duty <= 8'd100;
            cfg_reg.hold_tolerance <= 16'd10;
            cfg_reg.hold_duty <= 8'd80;
            cfg_reg.move_limit_ms <= 16'd5000;
            cfg_reg.stuck_timeout_ms <= 16'd500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POS_TOL:     cfg_reg.position_tolerance <= cfg_data;
                REG_SLOW_ZONE:   cfg_reg.slow_zone <= cfg_data;
                REG_NORMAL_DUTY: cfg_reg.normal_duty <= cfg_data[DUTY_W-1:0];
                REG_SLOW_DUTY:   cfg_reg.slow_duty <= cfg_data[DUTY_W-1:0];
                REG_HOLD_TOL:    cfg_reg.hold_tolerance <= cfg_data;
                REG_HOLD_DUTY:   cfg_reg.hold_duty <= cfg_data[DUTY_W-1:0];
                REG_MOVE_TMO:    cfg_reg.move_limit_ms <= cfg_data;
                REG_STUCK_TMO:   cfg_reg.stuck_timeout_ms <= cfg_data;
                default:         cfg_reg.stuck_timeout_ms <= cfg_reg.stuck_timeout_ms;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg <= s_tuser;
            enc_a_reg <= s_tdata[0];
            enc_b_reg <= s_tdata[1];
            strobe_reg <= s_tdata[2];
            tgt_in_reg <= s_tdata[33:3];
            hold_in_reg <= s_tdata[34];
        end
    end

    // controller state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            phase_reg <= '0;
            mode_reg <= MODE_IDLE;
            target_reg <= '0;
            hold_reg <= 1'b0;
            elapsed_reg <= '0;
            unch_reg <= '0;
            last_abs_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            mode_reg <= mode_next;
            target_reg <= target_next;
            hold_reg <= hold_next;
            elapsed_reg <= elapsed_next;
            unch_reg <= unch_next;
            last_abs_reg <= last_abs_next;
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            drive_reg <= drive_next;
            duty_reg <= duty_next;
            event_reg <= event_next;
        end
    end

endmodule

// ----- design/epc_checker.sv -----
// port-level checks on the controller results, bound to the top level
module epc_checker
    import epc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic [1:0]        drive;
    logic [DUTY_W-1:0] duty;
    logic [1:0]        event_res;
    logic [1:0]        mode;

    assign drive = m_tdata[1:0];
    assign duty = m_tdata[9:2];
    assign event_res = m_tdata[11:10];
    assign mode = m_tdata[13:12];

    // coast and brake never carry a duty
    a_no_duty_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (drive == DRV_COAST || drive == DRV_BRAKE) |-> duty == '0)
        else $error("duty set while coasting or braking");

    // an idle controller always lets the motor coast
    a_idle_coasts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && mode == MODE_IDLE |-> drive == DRV_COAST)
        else $error("drive active in idle mode");

    // a move still in progress pushes and reports no event
    a_moving_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && mode == MODE_MOVING
            |-> event_res == EV_NONE && (drive == DRV_FWD || drive == DRV_REV))
        else $error("moving result with event or without push");

    // holding either brakes or corrects, never coasts
    a_hold_no_coast: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && mode == MODE_HOLDING |-> drive != DRV_COAST)
        else $error("coast while holding");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

endmodule

bind encoder_position_controller_unit epc_checker u_epc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
